// ===== hdl/winograd_f2x3_input_tile_transform_core_assert.svh =====
// assertion macros used by the checker file
`ifndef WINOGRAD_F2X3_INPUT_TILE_TRANSFORM_CORE_ASSERT_SVH
`define WINOGRAD_F2X3_INPUT_TILE_TRANSFORM_CORE_ASSERT_SVH

// clocked assertion, off while reset is held
`define WF23_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("wf23 assertion failed");

// clocked assertion that also holds across reset
`define WF23_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("wf23 assertion failed");

`endif

// ===== hdl/wf23_pkg.sv =====
`default_nettype none

package wf23_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COORD_BITS      = 11;
    localparam int ROW_BITS        = 2;
    localparam int DIM_BITS        = 13;
    localparam int PAD_BITS        = 4;
    localparam int APB_ADDR_BITS   = 4;
    localparam int APB_DATA_BITS   = 32;

    localparam logic [ROW_BITS-1:0] LAST_ROW = 2'd3;

    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 13'd4;
    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 13'd4;
    localparam logic [PAD_BITS-1:0] PAD_RESET    = 4'd0;

    typedef enum logic [1:0] {
        REG_IMAGE_HEIGHT = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_PAD_TOP      = 2'd2,
        REG_PAD_LEFT     = 2'd3
    } cfg_reg_t;

endpackage

`default_nettype wire

// ===== hdl/winograd_f2x3_input_tile_transform_core.sv =====
// channel   | ports                        | contents
// ----------+------------------------------+------------------------------------------
// s_ (in)   | s_tvalid s_tready s_tdata    | one tile row: coordinates, row, 4 samples
// m_ (out)  | m_tvalid m_tready m_tdata    | one transformed row, m_tlast on row 3
//           | m_tlast                      |
// apb       | psel penable pwrite paddr .. | image height/width, top/left padding
//
// one item per cycle sustained while m_tready is high and no row 3 waits: an input register,
// then the mask and both transform passes as combinational logic into a four-row result
// buffer drained one row a cycle. a row 3 waits in the input register while the result
// buffer still holds rows of the previous tile, then moves into the result buffer, which
// shows result row 0 on m_; rows 0 to 2 never wait on the output side.
// aresetn is synchronous: both channels empty, config back to 4x4 with no padding.
`default_nettype none

module winograd_f2x3_input_tile_transform_core #(
    parameter int  SAMPLE_BITS = wf23_pkg::SAMPLE_BITS_DEF,
    localparam int S_DATA_BITS =
        ((2*wf23_pkg::COORD_BITS + wf23_pkg::ROW_BITS + 4*SAMPLE_BITS + 7) / 8) * 8,
    localparam int M_DATA_BITS =
        ((wf23_pkg::ROW_BITS + 4*(SAMPLE_BITS + 2) + 7) / 8) * 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // tile_row, tile_col, row_in_tile, sample_0, sample_1, sample_2, sample_3
    input  wire logic [S_DATA_BITS-1:0]             s_tdata,

    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // out_row, value_0, value_1, value_2, value_3
    output logic [M_DATA_BITS-1:0]                  m_tdata,
    output logic                                    m_tlast,

    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [wf23_pkg::APB_ADDR_BITS-1:0] paddr,
    input  wire logic [wf23_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [wf23_pkg::APB_DATA_BITS-1:0]      prdata,
    output logic                                    pready
);
    import wf23_pkg::*;

    localparam int PART_BITS = SAMPLE_BITS + 1;
    localparam int VAL_BITS  = SAMPLE_BITS + 2;
    localparam int POS_BITS  = DIM_BITS + 1;
    localparam int SAMP_LSB  = 2*COORD_BITS + ROW_BITS;

    // configuration
    logic [DIM_BITS-1:0] image_height_reg;
    logic [DIM_BITS-1:0] image_width_reg;
    logic [PAD_BITS-1:0] pad_top_reg;
    logic [PAD_BITS-1:0] pad_left_reg;
    logic                cfg_wr;
    cfg_reg_t            cfg_sel;

    // input register
    logic                          in_valid_reg;
    logic [COORD_BITS-1:0]         trow_reg;
    logic [COORD_BITS-1:0]         tcol_reg;
    logic [ROW_BITS-1:0]           rit_reg;
    logic signed [SAMPLE_BITS-1:0] samp_reg [4];

    // transform path
    logic                          advance;
    logic                          load_res;
    logic                          res_free;
    logic [POS_BITS-1:0]           row_pos;
    logic                          row_ok;
    logic [POS_BITS-1:0]           col_pos [4];
    logic                          col_ok  [4];
    logic signed [SAMPLE_BITS-1:0] samp_m  [4];
    logic signed [PART_BITS-1:0]   samp_x  [4];
    logic signed [PART_BITS-1:0]   hp      [4];
    logic signed [VAL_BITS-1:0]    vt      [4][4];

    // stored row partials and result buffer
    logic signed [PART_BITS-1:0]   part_reg [3][4];
    logic signed [VAL_BITS-1:0]    res_reg  [4][4];
    logic                          res_valid_reg;
    logic [ROW_BITS-1:0]           row_idx_reg;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = cfg_reg_t'(paddr[APB_ADDR_BITS-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_height_reg <= HEIGHT_RESET;
            image_width_reg  <= WIDTH_RESET;
            pad_top_reg      <= PAD_RESET;
            pad_left_reg     <= PAD_RESET;
        end else if (cfg_wr) begin
            case (cfg_sel)
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[DIM_BITS-1:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[DIM_BITS-1:0];
                REG_PAD_TOP:      pad_top_reg      <= pwdata[PAD_BITS-1:0];
                REG_PAD_LEFT:     pad_left_reg     <= pwdata[PAD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            REG_IMAGE_HEIGHT: prdata = APB_DATA_BITS'(image_height_reg);
            REG_IMAGE_WIDTH:  prdata = APB_DATA_BITS'(image_width_reg);
            REG_PAD_TOP:      prdata = APB_DATA_BITS'(pad_top_reg);
            REG_PAD_LEFT:     prdata = APB_DATA_BITS'(pad_left_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------- input register ----------------
    // buffer can take a new tile when empty or its last row leaves now
    assign res_free = !res_valid_reg || (m_tready && row_idx_reg == LAST_ROW);
    assign advance  = in_valid_reg && (rit_reg != LAST_ROW || res_free);
    assign load_res = advance && rit_reg == LAST_ROW;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            trow_reg <= s_tdata[COORD_BITS-1:0];
            tcol_reg <= s_tdata[2*COORD_BITS-1:COORD_BITS];
            rit_reg  <= s_tdata[SAMP_LSB-1:2*COORD_BITS];
            for (int c = 0; c < 4; c++) begin
                samp_reg[c] <= s_tdata[SAMP_LSB + c*SAMPLE_BITS +: SAMPLE_BITS];
            end
        end
    end

    // ---------------- padding mask and transforms ----------------
    // image position = 2*tile + offset - pad, tested as pad <= pos < limit + pad
    assign row_pos = POS_BITS'({trow_reg, 1'b0}) + POS_BITS'(rit_reg);
    assign row_ok  = (row_pos >= POS_BITS'(pad_top_reg))
                  && (row_pos < POS_BITS'(image_height_reg) + POS_BITS'(pad_top_reg));

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            col_pos[c] = POS_BITS'({tcol_reg, 1'b0}) + POS_BITS'(c);
            col_ok[c]  = (col_pos[c] >= POS_BITS'(pad_left_reg))
                      && (col_pos[c] < POS_BITS'(image_width_reg) + POS_BITS'(pad_left_reg));
            samp_m[c]  = (row_ok && col_ok[c]) ? samp_reg[c] : '0;
            samp_x[c]  = PART_BITS'(samp_m[c]);
        end
    end

    assign hp[0] = samp_x[0] - samp_x[2];
    assign hp[1] = samp_x[1] + samp_x[2];
    assign hp[2] = samp_x[2] - samp_x[1];
    assign hp[3] = samp_x[1] - samp_x[3];

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            vt[0][c] = VAL_BITS'(part_reg[0][c]) - VAL_BITS'(part_reg[2][c]);
            vt[1][c] = VAL_BITS'(part_reg[1][c]) + VAL_BITS'(part_reg[2][c]);
            vt[2][c] = VAL_BITS'(part_reg[2][c]) - VAL_BITS'(part_reg[1][c]);
            vt[3][c] = VAL_BITS'(part_reg[1][c]) - VAL_BITS'(hp[c]);
        end
    end

    // rows 0 to 2 overwrite their partials, never cleared after a tile
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 4; c++) begin
                    part_reg[r][c] <= '0;
                end
            end
        end else if (advance) begin
            for (int r = 0; r < 3; r++) begin
                if (rit_reg == ROW_BITS'(r)) begin
                    part_reg[r] <= hp;
                end
            end
        end
    end

    // ---------------- result buffer ----------------
    always_ff @(posedge aclk) begin
        if (load_res) begin
            res_reg <= vt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
            row_idx_reg   <= '0;
        end else if (load_res) begin
            res_valid_reg <= 1'b1;
            row_idx_reg   <= '0;
        end else if (res_valid_reg && m_tready) begin
            if (row_idx_reg == LAST_ROW) begin
                res_valid_reg <= 1'b0;
            end
            row_idx_reg <= row_idx_reg + 1'b1;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tlast  = row_idx_reg == LAST_ROW;

    always_comb begin
        m_tdata = '0;
        m_tdata[ROW_BITS-1:0] = row_idx_reg;
        for (int c = 0; c < 4; c++) begin
            m_tdata[ROW_BITS + c*VAL_BITS +: VAL_BITS] = res_reg[row_idx_reg][c];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/wf23_checker.sv =====
`default_nettype none

`include "winograd_f2x3_input_tile_transform_core_assert.svh"

module wf23_checker #(
    parameter int  SAMPLE_BITS = wf23_pkg::SAMPLE_BITS_DEF,
    localparam int M_DATA_BITS =
        ((wf23_pkg::ROW_BITS + 4*(SAMPLE_BITS + 2) + 7) / 8) * 8
) (
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_tready,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [M_DATA_BITS-1:0] m_tdata,
    input wire logic                   m_tlast
);
    import wf23_pkg::*;

    // a stalled result row holds
    `WF23_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // last marks exactly the final transformed row
    `WF23_ASSERT(a_last_row, aclk, aresetn, m_tvalid |-> (m_tlast == (m_tdata[ROW_BITS-1:0] == LAST_ROW)))

    // rows of one tile leave without gaps
    `WF23_ASSERT(a_tile_burst, aclk, aresetn, m_tvalid && m_tready && !m_tlast |=> m_tvalid)

    // with nothing pending on the output, the input side never stalls
    `WF23_ASSERT(a_no_stall, aclk, aresetn, !m_tvalid |-> s_tready)

    // reset empties both sides
    `WF23_ASSERT_NR(a_reset_empty, aclk, !aresetn |=> !m_tvalid && s_tready)

endmodule

bind winograd_f2x3_input_tile_transform_core wf23_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_wf23_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
